[sv/running_average_motion_mask_assert.svh]
// Assertion shorthands for the motion mask block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef RUNNING_AVERAGE_MOTION_MASK_ASSERT_SVH
`define RUNNING_AVERAGE_MOTION_MASK_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define RAMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define RAMM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[sv/ramm_pkg.sv]
package ramm_pkg;

  // Background store geometry
  localparam int FramePixels = 131072;
  localparam int AddrW       = (FramePixels > 1) ? $clog2(FramePixels) : 1;
  localparam int Chans       = 3;

  // Field widths
  localparam int IdxW    = 17;
  localparam int PixW    = 8;
  localparam int AccW    = 24;
  localparam int FracW   = 16;
  localparam int AlphaW  = 17;
  localparam int ThrW    = 8;
  localparam int GapW    = AccW + 1;
  localparam int ProdW   = AlphaW + 1 + GapW;
  localparam int DeltaW  = ProdW - FracW;
  localparam int NextW   = DeltaW + 1;
  localparam int SumW    = 23;
  localparam int GrayShift = 14;

  // Config port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = AlphaW;

  localparam logic [AlphaW-1:0] AlphaReset = AlphaW'(1311);
  localparam logic [ThrW-1:0]   ThrReset   = ThrW'(50);

  // Gray weights and rounding terms
  localparam logic [SumW-1:0] Weight0   = SumW'(4899);
  localparam logic [SumW-1:0] Weight1   = SumW'(9617);
  localparam logic [SumW-1:0] Weight2   = SumW'(1868);
  localparam logic [SumW-1:0] GrayRound = SumW'(8192);
  localparam logic [AccW:0]   AccHalf   = (AccW+1)'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA     = 2'd0,
    CFG_THRESHOLD = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0] pixel_index;
    logic [PixW-1:0] chan0;
    logic [PixW-1:0] chan1;
    logic [PixW-1:0] chan2;
    logic            end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic            moving;
    logic [PixW-1:0] difference_level;
    logic            frame_done;
  } out_item_t;

endpackage

[sv/ramm_ram.sv]
module ramm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write and one registered read per cycle; a read at the written
  // address returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[sv/running_average_motion_mask.sv]
// A pixel moves through stages 1 to 4 and the output register to its result.
// Throughput: one pixel per cycle without output stalls; a pixel whose index
// matches one of the two pixels just ahead of it waits for that background write.
// Reset: pipeline emptied, first-frame flag set, alpha = 1311, threshold = 50.
// The background memory is not cleared; the first frame loads each entry it writes.
`include "running_average_motion_mask_assert.svh"

module running_average_motion_mask (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ramm_pkg::in_item_t                  in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ramm_pkg::out_item_t                 out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ramm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ramm_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int Chans = ramm_pkg::Chans;
  localparam int AccW  = ramm_pkg::AccW;
  localparam int PixW  = ramm_pkg::PixW;

  // Configuration registers
  logic [ramm_pkg::AlphaW-1:0] alpha_q;
  logic [ramm_pkg::ThrW-1:0]   thr_q;
  logic                        first_q;

  // Stage 1: memory read data arrives, product computed
  logic                        s1_v_q, s1_first_q, s1_in_q, s1_eof_q;
  logic [ramm_pkg::IdxW-1:0]   s1_idx_q;
  logic [Chans-1:0][PixW-1:0]  s1_pix_q;
  logic [Chans-1:0][AccW-1:0]  rd_acc;

  // Stage 2: blend, saturate, write back
  logic                        s2_v_q, s2_first_q, s2_in_q, s2_eof_q;
  logic [ramm_pkg::IdxW-1:0]   s2_idx_q;
  logic [Chans-1:0][PixW-1:0]  s2_pix_q;
  logic [Chans-1:0][AccW-1:0]  s2_acc_q;
  logic signed [ramm_pkg::ProdW-1:0] s2_prod_q [Chans];

  // Stage 3: round and absolute difference
  logic                        s3_v_q, s3_in_q, s3_eof_q;
  logic [Chans-1:0][PixW-1:0]  s3_pix_q;
  logic [Chans-1:0][AccW-1:0]  s3_acc_q;

  // Stage 4: weighted gray level
  logic                        s4_v_q, s4_eof_q;
  logic [Chans-1:0][PixW-1:0]  s4_diff_q;

  // Output register
  logic                        out_v_q;
  ramm_pkg::out_item_t         out_q;

  logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;
  logic hazard, accept, in_range_d, ram_we;

  logic signed [ramm_pkg::ProdW-1:0] prod_d [Chans];
  logic [Chans-1:0][AccW-1:0]  acc_d;
  logic [Chans-1:0][PixW-1:0]  diff_d;
  logic [ramm_pkg::SumW-1:0]   sum_d;
  logic [PixW:0]               gray9;
  ramm_pkg::out_item_t         out_d;

  // Handshake: each stage moves when the next one is free or moving
  assign out_ready = !out_v_q || !out_stall_i;
  assign s4_ready  = !s4_v_q || out_ready;
  assign s3_ready  = !s3_v_q || s4_ready;
  assign s2_ready  = !s2_v_q || s3_ready;
  assign s1_ready  = !s1_v_q || s2_ready;

  // Interlock: hold a pixel while an older one for the same entry has not
  // yet written the memory
  assign hazard = (s1_v_q && (s1_idx_q == in_i.pixel_index)) ||
                  (s2_v_q && (s2_idx_q == in_i.pixel_index));

  assign in_stall_o  = !s1_ready || hazard;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign in_range_d  = 32'(in_i.pixel_index) < 32'(ramm_pkg::FramePixels);
  assign ram_we      = s2_v_q && s2_in_q && s3_ready;

  // Background store, three channels side by side
  ramm_ram #(
    .Width (Chans * AccW),
    .Depth (ramm_pkg::FramePixels)
  ) u_bg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ramm_pkg::AddrW'(s2_idx_q)),
    .wdata_i (acc_d),
    .re_i    (accept),
    .raddr_i (ramm_pkg::AddrW'(in_i.pixel_index)),
    .rdata_o (rd_acc)
  );

  // Stage 1 math: alpha * (pix*65536 - acc)
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      logic signed [ramm_pkg::GapW-1:0] gap;
      gap = $signed({1'b0, s1_pix_q[c], {ramm_pkg::FracW{1'b0}}}) -
            $signed({1'b0, rd_acc[c]});
      prod_d[c] = $signed({1'b0, alpha_q}) * gap;
    end
  end

  // Stage 2 math: floor shift, add, clamp to 24 bits; first frame loads pixel
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      logic signed [ramm_pkg::DeltaW-1:0] delta;
      logic signed [ramm_pkg::NextW-1:0]  nxt;
      delta = s2_prod_q[c][ramm_pkg::ProdW-1:ramm_pkg::FracW];
      nxt   = $signed({{(ramm_pkg::NextW-AccW){1'b0}}, s2_acc_q[c]}) +
              $signed({delta[ramm_pkg::DeltaW-1], delta});
      if (s2_first_q) begin
        acc_d[c] = {s2_pix_q[c], {ramm_pkg::FracW{1'b0}}};
      end else if (nxt[ramm_pkg::NextW-1]) begin
        acc_d[c] = '0;
      end else if (|nxt[ramm_pkg::NextW-2:AccW]) begin
        acc_d[c] = '1;
      end else begin
        acc_d[c] = nxt[AccW-1:0];
      end
    end
  end

  // Stage 3 math: round to 8 bits, absolute difference (zero for an out-of-range index)
  always_comb begin
    for (int c = 0; c < Chans; c++) begin
      logic [AccW:0]   rnd;
      logic [PixW-1:0] r8;
      rnd = {1'b0, s3_acc_q[c]} + ramm_pkg::AccHalf;
      r8  = rnd[AccW] ? '1 : rnd[AccW-1:ramm_pkg::FracW];
      if (!s3_in_q) begin
        diff_d[c] = '0;
      end else if (s3_pix_q[c] > r8) begin
        diff_d[c] = s3_pix_q[c] - r8;
      end else begin
        diff_d[c] = r8 - s3_pix_q[c];
      end
    end
  end

  // Stage 4 math: weighted sum, threshold compare
  always_comb begin
    sum_d = ramm_pkg::SumW'(s4_diff_q[0]) * ramm_pkg::Weight0 +
            ramm_pkg::SumW'(s4_diff_q[1]) * ramm_pkg::Weight1 +
            ramm_pkg::SumW'(s4_diff_q[2]) * ramm_pkg::Weight2 +
            ramm_pkg::GrayRound;
    gray9 = sum_d[ramm_pkg::SumW-1:ramm_pkg::GrayShift];
    out_d.difference_level = gray9[PixW] ? '1 : gray9[PixW-1:0];
    out_d.moving           = out_d.difference_level > thr_q;
    out_d.frame_done       = s4_eof_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ramm_pkg::AlphaReset;
      thr_q   <= ramm_pkg::ThrReset;
      first_q <= 1'b1;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ramm_pkg::CFG_ALPHA:     alpha_q <= cfg_data_i;
          ramm_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i[ramm_pkg::ThrW-1:0];
          default: ;
        endcase
      end
      if (accept && in_i.end_of_frame) begin
        first_q <= 1'b0;
      end
      if (s1_ready)  s1_v_q  <= accept;
      if (s2_ready)  s2_v_q  <= s1_v_q;
      if (s3_ready)  s3_v_q  <= s2_v_q;
      if (s4_ready)  s4_v_q  <= s3_v_q;
      if (out_ready) out_v_q <= s4_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && accept) begin
      s1_idx_q   <= in_i.pixel_index;
      s1_pix_q   <= {in_i.chan2, in_i.chan1, in_i.chan0};
      s1_eof_q   <= in_i.end_of_frame;
      s1_first_q <= first_q;
      s1_in_q    <= in_range_d;
    end
    if (s2_ready) begin
      s2_idx_q   <= s1_idx_q;
      s2_pix_q   <= s1_pix_q;
      s2_eof_q   <= s1_eof_q;
      s2_first_q <= s1_first_q;
      s2_in_q    <= s1_in_q;
      s2_acc_q   <= rd_acc;
      for (int c = 0; c < Chans; c++) begin
        s2_prod_q[c] <= prod_d[c];
      end
    end
    if (s3_ready) begin
      s3_pix_q <= s2_pix_q;
      s3_eof_q <= s2_eof_q;
      s3_in_q  <= s2_in_q;
      s3_acc_q <= acc_d;
    end
    if (s4_ready) begin
      s4_diff_q <= diff_d;
      s4_eof_q  <= s3_eof_q;
    end
    if (out_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Checks
  `RAMM_ASSERT_NEVER(a_no_rw_collision,
    ram_we && accept && (s2_idx_q == in_i.pixel_index),
    "memory read and write-back of the same entry in one cycle")
  `RAMM_ASSERT_NEVER(a_no_stale_pair,
    s1_v_q && s2_v_q && (s1_idx_q == s2_idx_q),
    "pixel read its entry before the older write-back")
  `RAMM_ASSERT(a_accept_loads_s1,
    accept |=> (s1_v_q && (s1_idx_q == $past(in_i.pixel_index))),
    "accepted transaction did not enter the first stage")
  `RAMM_ASSERT_NEVER(a_first_flag_rearm,
    $rose(first_q),
    "first-frame flag set again after reset")

endmodule

[verif/tb_top.sv]
module tb_top;
  import ramm_pkg::*;

  localparam int PoolSize     = 16;
  localparam int PhaseItems   = 210;
  localparam int Phases       = 8;
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 200;
  localparam int HoldFirst    = 520;
  localparam int HoldSpacing  = 830;
  localparam int CycleLimit   = 400000;
  localparam int LevelMax     = (1 << PixW) - 1;

  // Register indexes past the end of the map; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow of the background store, first-frame flag and registers
  bit [Chans-1:0][AccW-1:0] bg_avg [int];
  bit                       learn_first_frame = 1'b1;
  bit [AlphaW-1:0]          alpha_cfg = AlphaReset;
  bit [ThrW-1:0]            thr_cfg   = ThrReset;

  in_item_t    pixel_queue [$];
  out_item_t   mask_expected [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Sender burst state
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver stall state
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  int unsigned results_taken = 0;

  running_average_motion_mask dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Background update and gray difference for one accepted pixel
  function automatic out_item_t predict_mask(in_item_t px);
    bit [Chans-1:0][PixW-1:0] pix;
    bit [Chans-1:0][AccW-1:0] acc;
    int unsigned diff [Chans];
    int unsigned gray;
    int unsigned level;
    longint gap;
    longint delta;
    longint nxt;
    out_item_t res;
    pix[0] = px.chan0;
    pix[1] = px.chan1;
    pix[2] = px.chan2;
    for (int c = 0; c < Chans; c++) diff[c] = 0;
    if (px.pixel_index < FramePixels) begin
      if (!learn_first_frame) acc = bg_avg[int'(px.pixel_index)];
      for (int c = 0; c < Chans; c++) begin
        if (learn_first_frame) begin
          acc[c] = AccW'(pix[c]) << FracW;
        end else begin
          // floor(alpha * gap / 2^16), then clamp into the 8.16 range
          gap   = (longint'(pix[c]) <<< FracW) - longint'(acc[c]);
          delta = (longint'(alpha_cfg) * gap) >>> FracW;
          nxt   = longint'(acc[c]) + delta;
          if (nxt < 0) nxt = 0;
          if (nxt > (longint'(1) << AccW) - 1) nxt = (longint'(1) << AccW) - 1;
          acc[c] = nxt[AccW-1:0];
        end
        level = (int'(acc[c]) + int'(AccHalf)) >> FracW;
        if (level > LevelMax) level = LevelMax;
        diff[c] = (pix[c] > level) ? pix[c] - level : level - pix[c];
      end
      bg_avg[int'(px.pixel_index)] = acc;
    end
    gray = (diff[0] * Weight0 + diff[1] * Weight1 + diff[2] * Weight2 + GrayRound)
           >> GrayShift;
    if (gray > LevelMax) gray = LevelMax;
    res.moving           = gray > thr_cfg;
    res.difference_level = gray[PixW-1:0];
    res.frame_done       = px.end_of_frame;
    if (px.end_of_frame) learn_first_frame = 1'b0;
    return res;
  endfunction

  // Mostly random levels, with the rails showing up often
  function automatic logic [PixW-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PixW'($urandom);
    endcase
  endfunction

  function automatic void queue_pixel(logic [IdxW-1:0] idx, logic [PixW-1:0] c0,
                                      logic [PixW-1:0] c1, logic [PixW-1:0] c2,
                                      logic eof);
    in_item_t px;
    px.pixel_index  = idx;
    px.chan0        = c0;
    px.chan1        = c1;
    px.chan2        = c2;
    px.end_of_frame = eof;
    pixel_queue.push_back(px);
  endfunction

  // Register write; only called with the pipeline empty
  task automatic write_reg(logic [CfgIdxW-1:0] reg_idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (reg_idx == CFG_ALPHA) alpha_cfg = data;
    else if (reg_idx == CFG_THRESHOLD) thr_cfg = data[ThrW-1:0];
  endtask

  // Wait until every queued pixel is sent and every result is back
  task automatic drain();
    do @(posedge clk_i);
    while (pixel_queue.size() != 0 || in_valid_i || mask_expected.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0 || pixel_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_i       <= pixel_queue.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: random stall pattern redrawn periodically, plus two long hold-offs
  always @(posedge clk_i) begin
    logic stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) results_taken++;
      if (stall_tick % 64 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_tick++;
      if (hold_left == 0 && holds_done < 2 &&
          results_taken >= HoldFirst + holds_done * HoldSpacing) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  stall_next = 1'b0;
          STALL_LIGHT: stall_next = $urandom_range(0, 3) == 0;
          STALL_HEAVY: stall_next = $urandom_range(0, 9) < 7;
          default:     stall_next = (stall_tick % 5) < 2;
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) mask_expected.push_back(predict_mask(in_i));
      if (out_valid_o && !out_stall_i) begin
        if (mask_expected.size() == 0) begin
          $error("result transaction with no pixel pending");
          mismatches++;
        end else begin
          want = mask_expected.pop_front();
          if (out_o.moving !== want.moving) begin
            $error("moving: expected %0d, got %0d", want.moving, out_o.moving);
            mismatches++;
          end
          if (out_o.difference_level !== want.difference_level) begin
            $error("difference_level: expected %0d, got %0d",
                   want.difference_level, out_o.difference_level);
            mismatches++;
          end
          if (out_o.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, out_o.frame_done);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [IdxW-1:0]   pixel_pool [PoolSize];
    logic [IdxW-1:0]   last_idx;
    logic [IdxW-1:0]   prior_idx;
    logic [IdxW-1:0]   idx;
    logic [AlphaW-1:0] alpha_set;
    logic [ThrW-1:0]   thr_set;
    int                pick;

    // Small address pool so back-to-back hits on one entry are common;
    // all-zeros and all-ones indexes toggle every address bit
    pixel_pool[0] = '0;
    pixel_pool[1] = '1;
    pixel_pool[2] = 17'h0AAAA;
    pixel_pool[3] = 17'h15555;
    for (int k = 4; k < PoolSize; k++) pixel_pool[k] = IdxW'($urandom);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First frame loads every pool entry; the last pixel ends the frame
    for (int k = 0; k < PoolSize; k++) begin
      case (k)
        0: queue_pixel(pixel_pool[k], '0, '0, '0, 1'b0);
        1: queue_pixel(pixel_pool[k], '1, '1, '1, 1'b0);
        2: queue_pixel(pixel_pool[k], '0, '1, '0, 1'b0);
        3: queue_pixel(pixel_pool[k], '1, '0, '1, 1'b0);
        default: queue_pixel(pixel_pool[k], rand_level(), rand_level(), rand_level(),
                             k == PoolSize - 1);
      endcase
    end

    // Second frame at reset settings: full-scale swings, then a repeated index
    queue_pixel(pixel_pool[0], '1, '1, '1, 1'b0);
    queue_pixel(pixel_pool[1], '0, '0, '0, 1'b0);
    queue_pixel(pixel_pool[2], '1, '0, '1, 1'b0);
    queue_pixel(pixel_pool[3], '0, '1, '0, 1'b0);
    queue_pixel(pixel_pool[0], '1, '1, '1, 1'b0);
    queue_pixel(pixel_pool[0], '1, '1, '1, 1'b1);
    drain();

    // Unmapped register indexes
    write_reg(CfgSpareA, '1);
    write_reg(CfgSpareB, 17'h05A5A);

    last_idx  = pixel_pool[0];
    prior_idx = pixel_pool[1];
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin alpha_set = 17'd65536; thr_set = 8'd0;   end
        1: begin alpha_set = 17'd0;     thr_set = 8'd255; end
        2: begin alpha_set = '1;        thr_set = 8'd20;  end
        3: begin alpha_set = AlphaReset; thr_set = ThrReset; end
        4: begin alpha_set = 17'd32768; thr_set = 8'd128; end
        5: begin alpha_set = 17'd1;     thr_set = 8'd1;   end
        default: begin
          alpha_set = AlphaW'($urandom);
          thr_set   = ThrW'($urandom);
        end
      endcase
      write_reg(CFG_ALPHA, alpha_set);
      // junk in the upper data bits must not reach the threshold
      write_reg(CFG_THRESHOLD, {(CfgDataW - ThrW)'($urandom), thr_set});

      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) idx = last_idx;
        else if (pick == 1) idx = prior_idx;
        else idx = pixel_pool[$urandom_range(0, PoolSize - 1)];
        queue_pixel(idx, rand_level(), rand_level(), rand_level(),
                    $urandom_range(0, 39) == 0);
        prior_idx = last_idx;
        last_idx  = idx;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/ramm_pkg.sv
sv/ramm_ram.sv
sv/running_average_motion_mask.sv
verif/tb_top.sv
